[src/nat_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nat_pkg;

    localparam int ADDR_W = 64;
    localparam int OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch a new beat, arm the scan
        logic scan;    // walk the slot memory
        logic commit;  // apply the insert, load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[src/nat_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface nat_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic [63:0]               addr;

    modport source (output valid, output operation, output addr, input ready);
    modport sink   (input valid, input operation, input addr, output ready);
endinterface

interface nat_out_if;
    logic                      valid;
    logic                      ready;
    logic [63:0]               closest_addr;
    logic                      found;
    logic                      overflow;

    modport source (output valid, output closest_addr, output found, output overflow,
                    input ready);
    modport sink   (input valid, input closest_addr, input found, input overflow,
                    output ready);
endinterface

`default_nettype wire

[src/next_address_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake        Payload
// i_in      in   valid/ready      operation[1:0], addr[63:0]
// o_out     out  valid/ready      closest_addr[63:0], found, overflow
// i_cfg     in   i_cfg_we only    i_cfg_wdata (insert enable)
//
// Insert and query walk the used slots: the slot memory has one read port, so
// the scan reads one slot per cycle, and each read is registered before the slot
// is evaluated; a duplicate insert or an exact query match ends the scan sooner.
// Clear, ignored inserts and an empty table skip the scan. One beat is in flight
// at a time; a new one is accepted as soon as the result sits in the output
// register. Reset is synchronous, active low; it empties the table and sets
// insert enable. A stalled output holds the final state.

module next_address_table_top #(
    parameter int CAPACITY = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    nat_in_if.sink    i_in,
    nat_out_if.source o_out,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);
    import nat_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    nat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nat_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_operation    (i_in.operation),
        .i_addr         (i_in.addr),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_closest_addr (o_out.closest_addr),
        .o_found        (o_out.found),
        .o_overflow     (o_out.overflow)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

[src/nat_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module nat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  nat_pkg::t_sts i_sts,
    output nat_pkg::t_cmd o_cmd
);
    import nat_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register can take the beat
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_DONE: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/nat_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module nat_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nat_pkg::t_cmd              i_cmd,
    output nat_pkg::t_sts              o_sts,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic [nat_pkg::OP_W-1:0]   i_operation,
    input  logic [nat_pkg::ADDR_W-1:0] i_addr,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [nat_pkg::ADDR_W-1:0] o_closest_addr,
    output logic                       o_found,
    output logic                       o_overflow
);
    import nat_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [ADDR_W-1:0] r_mem [CAPACITY];
    logic [ADDR_W-1:0] r_rd_data;

    logic              r_ins_en;
    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic              r_ins_act;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_ev_vld;
    logic [IDX_W-1:0]  r_ev_idx;
    logic [ADDR_W-1:0] r_best;
    logic              r_dup;
    logic              r_free_vld;
    logic [IDX_W-1:0]  r_free_idx;
    logic [CNT_W-1:0]  r_used;

    logic              r_out_vld;
    logic [ADDR_W-1:0] r_out_closest;
    logic              r_out_found;
    logic              r_out_ovf;

    logic              stop;
    logic              issue;
    logic              ev_go;
    logic              q_clr;
    logic              room;
    logic              app;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [ADDR_W-1:0] mem_wd;
    logic              start_ins;

    // insert stops on a duplicate, query stops once the best equals the key
    assign stop   = (r_op == OP_INSERT) ? r_dup : (r_best == r_addr);
    assign issue  = i_cmd.scan && !stop && (r_rd_idx < r_len);
    assign ev_go  = i_cmd.scan && r_ev_vld && !stop;
    assign q_clr  = ev_go && (r_op == OP_QUERY) && (r_rd_data != '0) && (r_rd_data < r_addr);
    assign room   = r_free_vld || (r_used < CNT_W'(CAPACITY));
    assign app    = i_cmd.commit && r_ins_act && !r_dup;

    assign mem_we = q_clr || (app && room);
    assign mem_wa = q_clr ? r_ev_idx : (r_free_vld ? r_free_idx : r_used[IDX_W-1:0]);
    assign mem_wd = q_clr ? '0 : r_addr;

    assign start_ins = (t_op'(i_operation) == OP_INSERT) && r_ins_en && (i_addr != '0);

    assign o_sts.scan_done = stop || ((r_rd_idx >= r_len) && !r_ev_vld);
    assign o_sts.out_free  = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_ins_en <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_ev_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            r_ev_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op       <= t_op'(i_operation);
            r_addr     <= i_addr;
            r_ins_act  <= start_ins;
            r_len      <= (start_ins || (t_op'(i_operation) == OP_QUERY)) ? r_used : '0;
            r_rd_idx   <= '0;
            r_best     <= '0;
            r_dup      <= 1'b0;
            r_free_vld <= 1'b0;
        end else begin
            if (issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
                r_ev_idx <= r_rd_idx[IDX_W-1:0];
            end
            if (ev_go) begin
                if (r_op == OP_INSERT) begin
                    if (r_rd_data == r_addr) begin
                        r_dup <= 1'b1;
                    end
                    // remember the first empty slot for reuse
                    if ((r_rd_data == '0) && !r_free_vld) begin
                        r_free_vld <= 1'b1;
                        r_free_idx <= r_ev_idx;
                    end
                end else if ((r_rd_data != '0) && !(r_rd_data < r_addr) &&
                             ((r_best == '0) || (r_rd_data < r_best))) begin
                    r_best <= r_rd_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.commit) begin
            if (r_op == OP_CLEAR) begin
                r_used <= '0;
            end else if (app && !r_free_vld && (r_used < CNT_W'(CAPACITY))) begin
                r_used <= r_used + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_closest <= (r_op == OP_QUERY) ? r_best : '0;
            r_out_found   <= (r_op == OP_QUERY) && (r_best != '0);
            r_out_ovf     <= app && !room;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_closest_addr = r_out_closest;
    assign o_found        = r_out_found;
    assign o_overflow     = r_out_ovf;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(CAPACITY))
        else $error("slot count above capacity");

    a_ev_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> ((CNT_W'(r_ev_idx) + CNT_W'(1)) == r_rd_idx))
        else $error("evaluated slot not one behind read pointer");

    a_commit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_vld || i_ready))
        else $error("result register overwritten while still pending");

    a_ovf_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_ovf |-> !r_out_found && (r_out_closest == '0))
        else $error("overflow result carries a query answer");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import nat_pkg::*;

    localparam int CAPACITY = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = CAPACITY + 8;
    localparam int RANDOM_BEATS = 1280;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
    } t_request;

    typedef struct {
        logic [ADDR_W-1:0] closest_addr;
        logic              found;
        logic              overflow;
    } t_lookup;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    nat_in_if  in_if ();
    nat_out_if out_if ();

    next_address_table_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the table
    logic [ADDR_W-1:0] slot_shadow [0:CAPACITY-1];
    int unsigned       used_shadow = 0;
    logic              enable_shadow = 1'b1;

    t_request request_q [$];
    t_lookup  lookup_q [$];
    t_request next_request;
    t_lookup  got_lookup;
    bit       no_idle = 1'b0;
    int       error_count = 0;
    int       cycle_count = 0;
    int       random_beats = 0;

    function automatic t_lookup table_apply(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
        t_lookup           res;
        int unsigned       n;
        int unsigned       i;
        logic [ADDR_W-1:0] best;
        bit                done;
        res = '{closest_addr: '0, found: 1'b0, overflow: 1'b0};
        n = used_shadow;
        case (op)
            OP_INSERT: begin
                if (enable_shadow && addr != '0) begin
                    done = 1'b0;
                    for (i = 0; i < n; i++)
                        if (slot_shadow[i] == addr)
                            done = 1'b1;
                    // reuse the first emptied slot
                    for (i = 0; i < n; i++)
                        if (!done && slot_shadow[i] == '0) begin
                            slot_shadow[i] = addr;
                            done = 1'b1;
                        end
                    if (!done) begin
                        if (n >= CAPACITY) begin
                            res.overflow = 1'b1;
                        end else begin
                            slot_shadow[n] = addr;
                            used_shadow = n + 1;
                        end
                    end
                end
            end
            OP_QUERY: begin
                best = '0;
                i = 0;
                // stop once the best so far equals the query exactly
                while (i < n && best != addr) begin
                    if (slot_shadow[i] != '0) begin
                        if (slot_shadow[i] < addr)
                            slot_shadow[i] = '0;
                        else if (best == '0 || slot_shadow[i] < best)
                            best = slot_shadow[i];
                    end
                    i++;
                end
                res.closest_addr = best;
                res.found = (best != '0);
            end
            OP_CLEAR: begin
                used_shadow = 0;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (request_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 34)) begin
                next_request = request_q.pop_front();
                in_if.valid <= 1'b1;
                in_if.operation <= next_request.op;
                in_if.addr <= next_request.addr;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result monitor and prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= no_idle || ($urandom_range(0, 99) >= 34);
            if (out_if.valid && out_if.ready) begin
                if (lookup_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    error_count++;
                end else begin
                    got_lookup = lookup_q.pop_front();
                    if (out_if.closest_addr !== got_lookup.closest_addr) begin
                        $error("closest_addr: expected %h, actual %h",
                               got_lookup.closest_addr, out_if.closest_addr);
                        error_count++;
                    end
                    if (out_if.found !== got_lookup.found) begin
                        $error("found: expected %b, actual %b",
                               got_lookup.found, out_if.found);
                        error_count++;
                    end
                    if (out_if.overflow !== got_lookup.overflow) begin
                        $error("overflow: expected %b, actual %b",
                               got_lookup.overflow, out_if.overflow);
                        error_count++;
                    end
                end
            end
            if (in_if.valid && in_if.ready)
                lookup_q.push_back(table_apply(in_if.operation, in_if.addr));
        end
    end

    task automatic push_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
        request_q.push_back('{op: op, addr: addr});
    endtask

    function automatic logic [ADDR_W-1:0] wide_addr();
        return {$urandom, $urandom};
    endfunction

    // wait until the table is idle with nothing outstanding
    task automatic drain();
        do @(negedge i_clk);
        while (request_q.size() != 0 || in_if.valid || lookup_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_enable(logic value);
        drain();
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        enable_shadow = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr(logic [ADDR_W-1:0] base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return base + ADDR_W'($urandom_range(0, 40));
        else if (r < 82)
            return wide_addr();
        else if (r < 88)
            return '0;
        else if (r < 94)
            return ADDR_MAX - ADDR_W'($urandom_range(0, 3));
        return base;
    endfunction

    // clear, then insert around capacity so drops can happen
    task automatic fill_phase();
        int                count;
        logic [ADDR_W-1:0] recent;
        count = $urandom_range(60, 72);
        recent = wide_addr();
        push_request(OP_CLEAR, wide_addr());
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_request(OP_INSERT, recent);
            end else begin
                recent = wide_addr();
                push_request(OP_INSERT, recent);
            end
        end
        for (int k = 0; k < 4; k++)
            push_request(OP_QUERY, (k == 0) ? recent : wide_addr());
        random_beats += count + 5;
    endtask

    task automatic mixed_phase();
        int                count;
        int                r;
        logic [ADDR_W-1:0] base;
        count = $urandom_range(20, 40);
        base = $urandom_range(0, 2) == 0 ? '0 : (wide_addr() & ~ADDR_W'(16'hFFFF));
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                push_request(OP_INSERT, pick_addr(base));
            else if (r < 93)
                push_request(OP_QUERY, pick_addr(base));
            else if (r < 97)
                push_request(OP_CLEAR, wide_addr());
            else
                push_request(OP_NONE, wide_addr());
        end
        random_beats += count;
    endtask

    initial begin
        int phase;
        in_if.valid = 1'b0;
        in_if.operation = OP_INSERT;
        in_if.addr = '0;
        out_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_request(OP_QUERY, '0);
        push_request(OP_INSERT, '0);
        push_request(OP_INSERT, ADDR_MAX);
        push_request(OP_INSERT, 64'd1);
        push_request(OP_INSERT, 64'd1);
        push_request(OP_INSERT, 64'h8000_0000_0000_0000);
        push_request(OP_QUERY, '0);
        push_request(OP_QUERY, 64'd1);
        push_request(OP_QUERY, 64'd2);
        push_request(OP_INSERT, 64'd2);
        push_request(OP_QUERY, ADDR_MAX - 1);
        push_request(OP_QUERY, ADDR_MAX);
        push_request(OP_NONE, ADDR_MAX);
        push_request(OP_CLEAR, '0);
        push_request(OP_QUERY, 64'd5);
        push_request(OP_INSERT, 64'd5);
        push_request(OP_QUERY, 64'd6);
        write_enable(1'b0);
        push_request(OP_INSERT, 64'd7);
        push_request(OP_INSERT, 64'h5555_AAAA_5555_AAAA);
        push_request(OP_QUERY, 64'd1);
        write_enable(1'b1);
        push_request(OP_INSERT, 64'd7);
        push_request(OP_QUERY, 64'd7);
        drain();

        phase = 0;
        while (random_beats < RANDOM_BEATS) begin
            no_idle = (phase >= 8 && phase < 12);
            if (phase % 7 == 6)
                write_enable($urandom_range(0, 3) != 0);
            else if (phase % 7 == 0 && !enable_shadow)
                write_enable(1'b1);
            if ($urandom_range(0, 4) == 0)
                fill_phase();
            else
                mixed_phase();
            phase++;
        end

        drain();
        if (error_count == 0 && lookup_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
